// ===== src/kss_pkg.sv =====
// shared types, operation codes and the control program of the rank selector
package kss_pkg;

    // fixed field widths of the transactions
    localparam int VALUE_W = 16;
    localparam int RANK_W  = 10;

    // input transaction
    typedef struct packed {
        logic signed [VALUE_W-1:0] element_value;
        logic                      last_element;
        logic [RANK_W-1:0]         rank;
    } t_in_item;

    // result transaction
    typedef struct packed {
        logic signed [VALUE_W-1:0] selected_value;
        logic                      rank_clipped;
        logic                      overflow;
    } t_out_item;

    // datapath operations
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_LOAD    = 3'd0;
    localparam logic [OP_W-1:0] OP_PIVRD   = 3'd1;
    localparam logic [OP_W-1:0] OP_PIVCAP  = 3'd2;
    localparam logic [OP_W-1:0] OP_COUNT   = 3'd3;
    localparam logic [OP_W-1:0] OP_DECIDE  = 3'd4;
    localparam logic [OP_W-1:0] OP_COMPACT = 3'd5;
    localparam logic [OP_W-1:0] OP_NEXT    = 3'd6;
    localparam logic [OP_W-1:0] OP_EMIT    = 3'd7;

    // sequencing conditions
    localparam int COND_W = 2;
    localparam logic [COND_W-1:0] C_NEXT = 2'd0;
    localparam logic [COND_W-1:0] C_GOTO = 2'd1;
    localparam logic [COND_W-1:0] C_HOLD = 2'd2;
    localparam logic [COND_W-1:0] C_HIT  = 2'd3;

    // program steps
    localparam int PC_W = 3;
    localparam logic [PC_W-1:0] ST_LOAD    = 3'd0;
    localparam logic [PC_W-1:0] ST_PIVRD   = 3'd1;
    localparam logic [PC_W-1:0] ST_PIVCAP  = 3'd2;
    localparam logic [PC_W-1:0] ST_COUNT   = 3'd3;
    localparam logic [PC_W-1:0] ST_DECIDE  = 3'd4;
    localparam logic [PC_W-1:0] ST_COMPACT = 3'd5;
    localparam logic [PC_W-1:0] ST_NEXT    = 3'd6;
    localparam logic [PC_W-1:0] ST_EMIT    = 3'd7;

    // one control word
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } t_uword;

    // control from sequencer to datapath
    typedef struct packed {
        logic [OP_W-1:0] op;
    } t_ctl;

    // status from datapath to sequencer
    typedef struct packed {
        logic hold;
        logic hit;
    } t_flags;

    // control store: hold means stay on the step, else go to target
    function automatic t_uword uop_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            ST_LOAD:    w = '{op: OP_LOAD,    cond: C_HOLD, target: ST_PIVRD};
            ST_PIVRD:   w = '{op: OP_PIVRD,   cond: C_NEXT, target: ST_LOAD};
            ST_PIVCAP:  w = '{op: OP_PIVCAP,  cond: C_NEXT, target: ST_LOAD};
            ST_COUNT:   w = '{op: OP_COUNT,   cond: C_HOLD, target: ST_DECIDE};
            ST_DECIDE:  w = '{op: OP_DECIDE,  cond: C_HIT,  target: ST_EMIT};
            ST_COMPACT: w = '{op: OP_COMPACT, cond: C_HOLD, target: ST_NEXT};
            ST_NEXT:    w = '{op: OP_NEXT,    cond: C_GOTO, target: ST_PIVRD};
            ST_EMIT:    w = '{op: OP_EMIT,    cond: C_HOLD, target: ST_LOAD};
            default:    w = '{op: OP_LOAD,    cond: C_GOTO, target: ST_LOAD};
        endcase
        return w;
    endfunction

endpackage

// ===== src/kss_ram.sv =====
// generic single-write, single-read memory with registered read data
module kss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/kss_seq.sv =====
// step counter and control store of the selection program
module kss_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  kss_pkg::t_flags i_flags,
    output kss_pkg::t_ctl   o_ctl
);

    logic [kss_pkg::PC_W-1:0] r_pc;
    logic [kss_pkg::PC_W-1:0] n_pc;
    kss_pkg::t_uword          w_uw;

    assign w_uw     = kss_pkg::uop_rom(r_pc);
    assign o_ctl.op = w_uw.op;

    // next step selection
    always_comb begin
        case (w_uw.cond)
            kss_pkg::C_NEXT: n_pc = r_pc + kss_pkg::PC_W'(1);
            kss_pkg::C_GOTO: n_pc = w_uw.target;
            kss_pkg::C_HOLD: n_pc = i_flags.hold ? r_pc : w_uw.target;
            kss_pkg::C_HIT:  n_pc = i_flags.hit ? w_uw.target : r_pc + kss_pkg::PC_W'(1);
            default:         n_pc = kss_pkg::ST_LOAD;
        endcase
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= kss_pkg::ST_LOAD;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== src/kss_datapath.sv =====
// value store, scan counters and compare logic driven by the control word
module kss_datapath #(
    parameter int CAPACITY = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kss_pkg::t_ctl      i_ctl,
    output kss_pkg::t_flags    o_flags,
    input  logic               i_in_valid,
    input  kss_pkg::t_in_item  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output kss_pkg::t_out_item o_out_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > kss_pkg::RANK_W) ? CW : kss_pkg::RANK_W;

    logic [CW-1:0]                      r_count;
    logic                               r_drop;
    logic [CW-1:0]                      r_len;
    logic [CW-1:0]                      r_next_len;
    logic [CW-1:0]                      r_k;
    logic                               r_clip;
    logic [CW-1:0]                      r_rd;
    logic [CW-1:0]                      r_wr;
    logic                               r_dv;
    logic [CW-1:0]                      r_less;
    logic [CW-1:0]                      r_eq;
    logic signed [kss_pkg::VALUE_W-1:0] r_pivot;
    logic                               r_upper;
    logic                               r_out_valid;
    kss_pkg::t_out_item                 r_out;
    logic                               n_out_valid;

    logic                               w_take;
    logic                               w_room;
    logic [CW-1:0]                      w_cnt_after;
    logic [CW-1:0]                      w_top;
    logic                               w_clip;
    logic [CW-1:0]                      w_k;
    logic                               w_issue;
    logic [CW-1:0]                      w_mid;
    logic [CW-1:0]                      w_le;
    logic                               w_hit;
    logic                               w_lt;
    logic                               w_eq;
    logic                               w_keep;
    logic                               w_scan;
    logic                               w_hold;
    logic                               w_emit;
    logic                               w_we;
    logic [AW-1:0]                      w_waddr;
    logic [kss_pkg::VALUE_W-1:0]        w_wdata;
    logic [AW-1:0]                      w_raddr;
    logic [kss_pkg::VALUE_W-1:0]        w_rdata;

    // value store
    kss_ram #(
        .WIDTH(kss_pkg::VALUE_W),
        .DEPTH(CAPACITY)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // loading and rank clipping
    assign w_take      = i_in_valid && (i_ctl.op == kss_pkg::OP_LOAD);
    assign w_room      = r_count < CW'(CAPACITY);
    assign w_cnt_after = w_room ? r_count + CW'(1) : r_count;
    assign w_top       = w_cnt_after - CW'(1);
    assign w_clip      = XW'(i_in_data.rank) > XW'(w_top);
    assign w_k         = w_clip ? w_top : CW'(i_in_data.rank);

    // scan and compare
    assign w_issue = r_rd < r_len;
    assign w_mid   = (r_len - CW'(1)) >> 1;
    assign w_le    = r_less + r_eq;
    assign w_hit   = (r_k >= r_less) && (r_k < w_le);
    assign w_lt    = $signed(w_rdata) < r_pivot;
    assign w_eq    = $signed(w_rdata) == r_pivot;
    assign w_keep  = r_upper ? (!w_lt && !w_eq) : w_lt;
    assign w_scan  = w_issue || r_dv;

    // hold condition of the current step
    always_comb begin
        case (i_ctl.op)
            kss_pkg::OP_LOAD:    w_hold = !(w_take && i_in_data.last_element);
            kss_pkg::OP_COUNT:   w_hold = w_scan;
            kss_pkg::OP_COMPACT: w_hold = w_scan;
            kss_pkg::OP_EMIT:    w_hold = r_out_valid && i_out_stall;
            default:             w_hold = 1'b0;
        endcase
    end

    assign w_emit        = (i_ctl.op == kss_pkg::OP_EMIT) && !w_hold;
    assign o_flags.hold  = w_hold;
    assign o_flags.hit   = w_hit;

    // memory port selection
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_count[AW-1:0];
        w_wdata = i_in_data.element_value;
        w_raddr = r_rd[AW-1:0];
        case (i_ctl.op)
            kss_pkg::OP_LOAD: begin
                w_we = w_take && w_room;
            end
            kss_pkg::OP_PIVRD: begin
                w_raddr = w_mid[AW-1:0];
            end
            kss_pkg::OP_COMPACT: begin
                w_we    = r_dv && w_keep;
                w_waddr = r_wr[AW-1:0];
                w_wdata = w_rdata;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // result register handshake
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (w_emit) begin
            n_out_valid = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_take) begin
                if (w_room) begin
                    r_count <= w_cnt_after;
                end else begin
                    r_drop <= 1'b1;
                end
            end
            if (w_emit) begin
                r_count <= '0;
                r_drop  <= 1'b0;
            end
        end
    end

    // working registers of the selection passes
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            kss_pkg::OP_LOAD: begin
                if (w_take && i_in_data.last_element) begin
                    r_len  <= w_cnt_after;
                    r_k    <= w_k;
                    r_clip <= w_clip;
                end
            end
            kss_pkg::OP_PIVCAP: begin
                r_pivot <= $signed(w_rdata);
                r_rd    <= '0;
                r_wr    <= '0;
                r_dv    <= 1'b0;
                r_less  <= '0;
                r_eq    <= '0;
            end
            kss_pkg::OP_COUNT: begin
                if (w_issue) begin
                    r_rd <= r_rd + CW'(1);
                end
                r_dv <= w_issue;
                if (r_dv) begin
                    r_less <= r_less + CW'(w_lt);
                    r_eq   <= r_eq + CW'(w_eq);
                end
            end
            kss_pkg::OP_DECIDE: begin
                r_rd <= '0;
                r_wr <= '0;
                r_dv <= 1'b0;
                if (r_k < r_less) begin
                    r_upper    <= 1'b0;
                    r_next_len <= r_less;
                end else begin
                    r_upper    <= 1'b1;
                    r_next_len <= r_len - w_le;
                    if (!w_hit) begin
                        r_k <= r_k - w_le;
                    end
                end
            end
            kss_pkg::OP_COMPACT: begin
                if (w_issue) begin
                    r_rd <= r_rd + CW'(1);
                end
                r_dv <= w_issue;
                if (r_dv && w_keep) begin
                    r_wr <= r_wr + CW'(1);
                end
            end
            kss_pkg::OP_NEXT: begin
                r_len <= r_next_len;
            end
            kss_pkg::OP_EMIT: begin
                if (w_emit) begin
                    r_out.selected_value <= r_pivot;
                    r_out.rank_clipped   <= r_clip;
                    r_out.overflow       <= r_drop;
                end
            end
            default: begin
                r_dv <= r_dv;
            end
        endcase
    end

    assign o_in_stall  = i_ctl.op != kss_pkg::OP_LOAD;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== src/kth_smallest_select.sv =====
// top level of the rank selector: loads a set of values and returns the k-th smallest
// loading: one transaction per cycle, the final one starts selection
// selection: each pass scans the live range through the single read port of the store to
// count, then, unless the rank falls among the values equal to the pivot, scans it again
// to compact; the result register frees the input side
// reset: sequencer, fill count, overflow flag and result valid clear; store needs no clearing
module kth_smallest_select #(
    parameter int CAPACITY = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  kss_pkg::t_in_item  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output kss_pkg::t_out_item o_out_data
);

    kss_pkg::t_ctl   w_ctl;
    kss_pkg::t_flags w_flags;

    // program sequencer
    kss_seq u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_flags(w_flags),
        .o_ctl  (w_ctl)
    );

    // datapath with value store
    kss_datapath #(
        .CAPACITY(CAPACITY)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .o_flags    (w_flags),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    // the final transaction of a set closes the input side for selection
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.last_element) |=> o_in_stall)
        else $error("input not stalled after final transaction");

    // a result only appears from the emit step
    a_rise_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_ctl.op == kss_pkg::OP_EMIT))
        else $error("result raised outside emit step");

    // leaving the emit step always presents a result
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.op == kss_pkg::OP_EMIT && !w_flags.hold) |=> o_out_valid)
        else $error("emit step left without result");

endmodule

// ===== sim/kth_check_pkg.sv =====
// scoreboard for the rank selector: predicted picks per loaded set and result checking
`timescale 1ns / 100ps

package kth_check_pkg;

    import kss_pkg::*;

    class kth_check;
        logic signed [VALUE_W-1:0] loaded_set[$];
        bit                        dropped;
        t_out_item                 expected_picks[$];
        int                        fails;
        int                        store_depth;

        function new(int depth);
            store_depth = depth;
            dropped     = 1'b0;
            fails       = 0;
        endfunction

        // count a failure, report only the first few
        function void flag(string msg);
            fails++;
            if (fails <= 10) begin
                $display("%s", msg);
            end
        endfunction

        // k-th smallest of the loaded set, found by counting smaller and equal values
        function logic signed [VALUE_W-1:0] pick_rank(int k);
            int less;
            int equal;
            for (int i = 0; i < loaded_set.size(); i++) begin
                less  = 0;
                equal = 0;
                for (int j = 0; j < loaded_set.size(); j++) begin
                    if (loaded_set[j] < loaded_set[i]) begin
                        less++;
                    end else if (loaded_set[j] == loaded_set[i]) begin
                        equal++;
                    end
                end
                if (k >= less && k < less + equal) begin
                    return loaded_set[i];
                end
            end
            return loaded_set[0];
        endfunction

        // accepted input transaction: store the value, predict a pick on the last one
        function void note_item(t_in_item it);
            t_out_item pick;
            int        k;
            if (loaded_set.size() < store_depth) begin
                loaded_set.push_back(it.element_value);
            end else begin
                dropped = 1'b1;
            end
            if (it.last_element) begin
                k = int'(it.rank);
                pick.rank_clipped = 1'b0;
                if (k > loaded_set.size() - 1) begin
                    k = loaded_set.size() - 1;
                    pick.rank_clipped = 1'b1;
                end
                pick.selected_value = pick_rank(k);
                pick.overflow       = dropped;
                expected_picks.push_back(pick);
                loaded_set.delete();
                dropped = 1'b0;
            end
        endfunction

        // accepted result transaction against the oldest prediction
        function void check_pick(t_out_item got);
            t_out_item want;
            if (expected_picks.size() == 0) begin
                flag($sformatf("unexpected result: value %0d clipped %0b overflow %0b",
                               got.selected_value, got.rank_clipped, got.overflow));
                return;
            end
            want = expected_picks.pop_front();
            if (got.selected_value !== want.selected_value ||
                got.rank_clipped !== want.rank_clipped ||
                got.overflow !== want.overflow) begin
                flag($sformatf({"result mismatch: expected value %0d clipped %0b overflow %0b,",
                                " got value %0d clipped %0b overflow %0b"},
                               want.selected_value, want.rank_clipped, want.overflow,
                               got.selected_value, got.rank_clipped, got.overflow));
            end
        endfunction

        function int pending();
            return expected_picks.size();
        endfunction

        // predictions that never got a result
        function void close();
            if (expected_picks.size() != 0) begin
                flag($sformatf("%0d predicted results never arrived", expected_picks.size()));
            end
        endfunction
    endclass

endpackage

// ===== sim/tb_top.sv =====
// testbench top of the rank selector: directed and random sets, random idling on both sides
`timescale 1ns / 100ps

module tb_top;

    import kss_pkg::*;
    import kth_check_pkg::*;

    localparam int STORE_DEPTH = 1024;
    localparam int ITEM_TARGET = 1450;
    localparam int SET_TARGET  = 48;

    typedef enum int {VAL_FULL, VAL_NARROW, VAL_EXTREME} t_value_mode;
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_LONG} t_stall_mode;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        in_valid  = 1'b0;
    t_in_item    in_data   = '0;
    logic        in_stall;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_data;

    kth_check    sb;
    int          burst_left = 0;
    int          items_sent = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int          mode_left  = 0;
    int          hold_left  = 0;

    kth_smallest_select #(
        .CAPACITY(STORE_DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .i_in_data  (in_data),
        .o_in_stall (in_stall),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // accepted transactions on both sides
    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && !in_stall) begin
            sb.note_item(in_data);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            sb.check_pick(out_data);
        end
    end

    // receiver stall pattern: modes of random length, from none to long hold-offs
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            mode_left  <= $urandom_range(50, 400);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            STALL_NONE: begin
                out_stall <= 1'b0;
            end
            STALL_LIGHT: begin
                out_stall <= ($urandom_range(0, 3) == 0);
            end
            STALL_HEAVY: begin
                out_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                if (hold_left > 0) begin
                    hold_left <= hold_left - 1;
                    out_stall <= 1'b1;
                end else begin
                    out_stall <= 1'b0;
                    hold_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(1, 30) : 0;
                end
            end
        endcase
    end

    // random value of the chosen flavor
    function automatic logic signed [VALUE_W-1:0] make_value(t_value_mode m);
        logic signed [VALUE_W-1:0] v;
        case (m)
            VAL_NARROW: begin
                v = VALUE_W'($urandom_range(0, 8));
                v = v - 16'sd4;
            end
            VAL_EXTREME: begin
                case ($urandom_range(0, 3))
                    0:       v = 16'sh8000;
                    1:       v = 16'sh7fff;
                    2:       v = 16'sh0000;
                    default: v = -16'sd1;
                endcase
            end
            default: begin
                v = VALUE_W'($urandom);
            end
        endcase
        return v;
    endfunction

    // one input transaction, called at a falling edge; bursts with random gaps
    task automatic send_item(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 10);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 30);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (in_stall);
        burst_left--;
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic put_value(input logic signed [VALUE_W-1:0] v, input logic last,
                             input logic [RANK_W-1:0] rank);
        t_in_item it;
        it.element_value = v;
        it.last_element  = last;
        it.rank          = rank;
        send_item(it);
    endtask

    // one set of n values; rank on non-final items is junk the block ignores
    task automatic send_set(input int n, input t_value_mode m, input logic [RANK_W-1:0] rank);
        logic [RANK_W-1:0] junk_rank;
        for (int i = 0; i < n; i++) begin
            junk_rank = RANK_W'($urandom);
            put_value(make_value(m), i == n - 1, (i == n - 1) ? rank : junk_rank);
        end
    endtask

    // main sequence
    initial begin
        int          n;
        int          lim;
        int          r;
        int          sets_done;
        int          overflow_at;
        logic [RANK_W-1:0] rank;
        t_value_mode vmode;

        sb = new(STORE_DEPTH);
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // single value sets at both extremes, one with an oversized rank
        put_value(16'sh7fff, 1'b1, 10'd0);
        put_value(16'sh8000, 1'b1, 10'd1023);
        // duplicates around a lone zero
        put_value(16'sd5, 1'b0, 10'd0);
        put_value(-16'sd3, 1'b0, 10'd0);
        put_value(16'sd5, 1'b0, 10'd0);
        put_value(16'sd5, 1'b0, 10'd0);
        put_value(16'sd0, 1'b1, 10'd2);
        // all equal, the partition cannot shrink
        repeat (3) put_value(-16'sd1, 1'b0, 10'd1023);
        put_value(-16'sd1, 1'b1, 10'd3);
        // extremes mixed, top rank
        put_value(16'sh7fff, 1'b0, 10'd0);
        put_value(16'sh8000, 1'b0, 10'd0);
        put_value(16'sd0, 1'b0, 10'd0);
        put_value(16'sd1, 1'b0, 10'd0);
        put_value(-16'sd1, 1'b1, 10'd4);
        // descending order, lowest rank
        put_value(16'sd300, 1'b0, 10'd0);
        put_value(16'sd200, 1'b0, 10'd0);
        put_value(16'sd100, 1'b0, 10'd0);
        put_value(16'sd0, 1'b0, 10'd0);
        put_value(-16'sd100, 1'b1, 10'd0);
        // rank at count minus one, then at count
        put_value(16'sd7, 1'b0, 10'd0);
        put_value(-16'sd7, 1'b1, 10'd1);
        put_value(16'sd7, 1'b0, 10'd0);
        put_value(-16'sd7, 1'b1, 10'd2);

        // random sets, mostly small, one that overruns the store
        sets_done   = 0;
        overflow_at = $urandom_range(5, 30);
        while (items_sent < ITEM_TARGET || sets_done < SET_TARGET) begin
            if (sets_done == overflow_at) begin
                n = STORE_DEPTH + $urandom_range(1, 6);
            end else if ($urandom_range(0, 4) != 0) begin
                n = $urandom_range(1, 6);
            end else begin
                n = $urandom_range(7, 40);
            end
            lim   = (n > STORE_DEPTH) ? STORE_DEPTH : n;
            vmode = t_value_mode'($urandom_range(0, 2));
            r     = $urandom_range(0, 19);
            if (r < 15) begin
                rank = RANK_W'($urandom_range(0, lim - 1));
            end else if (r < 17) begin
                rank = RANK_W'(lim - 1);
            end else begin
                rank = RANK_W'($urandom_range(0, 1023));
            end
            send_set(n, vmode, rank);
            sets_done++;
        end
        in_valid <= 1'b0;

        // drain, then watch for stray results
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        sb.close();
        if (sb.fails == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog
    initial begin
        #50_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
